/* rtl/core/i2c_slave_memory_responder_defines.svh */
// assertion macros shared by the i2c memory responder modules
// no dependencies; each macro expects clk and rst_n in scope
`ifndef I2C_SLAVE_MEMORY_RESPONDER_DEFINES_SVH
`define I2C_SLAVE_MEMORY_RESPONDER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/i2cm_pkg.sv */
// shared types and constants of the i2c memory responder
// no dependencies; imported by every module of the block
package i2cm_pkg;

  // memory address width; depth follows from it
  localparam int MEM_AW    = 8;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  localparam int MODE_W = 3;

  // bus controller status events
  typedef enum logic [MODE_W-1:0] {
    EV_ADDR_WRITE = 3'd0,
    EV_DATA_RX    = 3'd1,
    EV_ADDR_READ  = 3'd2,
    EV_TX_NACK    = 3'd3,
    EV_RX_NACK    = 3'd4,
    EV_STOP       = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_en;
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_stall;
  } dp_status_t;

endpackage

/* rtl/core/i2cm_ctrl.sv */
// controller state machine of the i2c memory responder
// depends on i2cm_pkg and the assertion macro header
`include "i2c_slave_memory_responder_defines.svh"

module i2cm_ctrl
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  dp_status_t  status,
  output ctrl_cmd_t   cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!status.out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd.clear_en = 1'b0;
    cmd.capture  = 1'b0;
    cmd.execute  = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clear_en = 1'b1;
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_EXEC: cmd.execute = !status.out_stall;
      default: ;
    endcase
  end

  `I2CM_ASSERT_NEXT(a_capture_to_exec, cmd.capture, state_r == ST_EXEC, "capture not followed by exec")
  `I2CM_ASSERT_NEXT(a_exec_to_idle, cmd.execute, in_tready, "not ready after execute")

endmodule

/* rtl/core/i2cm_datapath.sv */
// datapath: event registers, pointer, memory and output stage
// depends on i2cm_pkg and the assertion macro header
`include "i2c_slave_memory_responder_defines.svh"

module i2cm_datapath
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_valid,
  output logic        out_handled
);

  logic [MODE_W-1:0] mode_r;
  logic [7:0]        rx_r;
  logic [1:0]        byte_count_r, byte_count_nxt;
  logic [7:0]        first_r, first_nxt;
  logic [MEM_AW-1:0] pointer_r, pointer_nxt;
  logic [MEM_AW-1:0] clr_addr_r;
  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rd_data_r;
  logic              wr_en;
  logic [15:0]       addr_word;
  logic              tx_valid_nxt, handled_nxt;
  logic              out_valid_r;
  logic [7:0]        tx_byte_r;
  logic              tx_valid_r, handled_r;

  assign addr_word = {first_r, rx_r};

  always_comb begin
    byte_count_nxt = byte_count_r;
    first_nxt      = first_r;
    pointer_nxt    = pointer_r;
    wr_en          = 1'b0;
    tx_valid_nxt   = 1'b0;
    handled_nxt    = 1'b1;
    case (mode_r) inside
      EV_ADDR_WRITE, EV_RX_NACK, EV_STOP: byte_count_nxt = 2'd0;
      EV_DATA_RX: begin
        case (byte_count_r)
          2'd1: begin
            pointer_nxt    = addr_word[MEM_AW-1:0];
            byte_count_nxt = 2'd2;
          end
          2'd2: begin
            wr_en          = 1'b1;
            byte_count_nxt = 2'd0;
          end
          default: begin
            first_nxt      = rx_r;
            byte_count_nxt = 2'd1;
          end
        endcase
      end
      EV_ADDR_READ: begin
        tx_valid_nxt = 1'b1;
        pointer_nxt  = pointer_r + 1'b1;
      end
      EV_TX_NACK: ;
      default: handled_nxt = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      first_r      <= '0;
      pointer_r    <= '0;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clear_en) clr_addr_r <= clr_addr_r + 1'b1;
      if (cmd.execute) begin
        byte_count_r <= byte_count_nxt;
        first_r      <= first_nxt;
        pointer_r    <= pointer_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      rx_r   <= in_rx_byte;
    end
    if (cmd.execute) begin
      tx_byte_r  <= tx_valid_nxt ? rd_data_r : 8'd0;
      tx_valid_r <= tx_valid_nxt;
      handled_r  <= handled_nxt;
    end
  end

  // memory: one write port, one registered read at the pointer
  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      mem[clr_addr_r] <= 8'd0;
    end else if (cmd.execute && wr_en) begin
      mem[pointer_r] <= rx_r;
    end
    rd_data_r <= mem[pointer_r];
  end

  assign status.clear_last = (clr_addr_r == {MEM_AW{1'b1}});
  assign status.out_stall  = out_valid_r && !out_ready;

  assign out_valid    = out_valid_r;
  assign out_tx_byte  = tx_byte_r;
  assign out_tx_valid = tx_valid_r;
  assign out_handled  = handled_r;

  `I2CM_ASSERT_NOW(a_tx_zero, out_valid_r && !tx_valid_r, tx_byte_r == 8'd0, "tx byte set without tx valid")
  `I2CM_ASSERT_NOW(a_count_range, 1'b1, byte_count_r != 2'd3, "byte count reached three")
  `I2CM_ASSERT_NOW(a_no_overwrite, cmd.execute, !(out_valid_r && !out_ready), "result overwritten")

endmodule

/* rtl/core/i2c_slave_memory_responder.sv */
// top level of the i2c slave memory responder
// depends on i2cm_pkg, i2cm_ctrl and i2cm_datapath
//
// slave side of an i2c byte-addressed memory of MEM_DEPTH bytes (256 here).
// each input beat is one bus-controller status event (in_tuser) with the
// received byte (in_tdata); each yields exactly one result beat. in a write
// transfer the first two data bytes (high, low) set the pointer, reduced to
// the memory size, and the third is stored at the pointer, then the byte
// count restarts. a read start returns the byte at the pointer and then
// increments it with wraparound. own-address write, rx nack and stop/restart
// clear the byte count; tx nack is acknowledged with no other effect; other
// codes give an all-zero result. an event is captured while the memory reads
// at the pointer; then state is updated and the output register loaded, which
// waits while the output register stays full because out_tready is low.
// a new event can be taken while a result waits. after reset a clearing pass
// writes zero to every memory entry, one entry a cycle, with in_tready low.
module i2c_slave_memory_responder
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [2:0]  in_tuser,   // [2:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] tx_byte
  output logic [1:0]  out_tuser   // [0] tx_valid, [1] handled
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencing: clear pass, wait for event, execute
  i2cm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // event decode, pointer, memory and output register
  i2cm_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_mode      (in_tuser),
    .in_rx_byte   (in_tdata),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_tx_byte  (out_tdata),
    .out_tx_valid (out_tuser[0]),
    .out_handled  (out_tuser[1])
  );

endmodule
